FILE: design/cms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants for the cluster makespan scheduler: time
// widths, controller states and the request broadcast to the cell row.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int unsigned MAX_PROCESSORS_DEF = 64;
    localparam int unsigned TIME_W             = 32;
    localparam int unsigned FIELD_W            = 31;
    localparam int unsigned CFG_W              = 7;

    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic  apply;
        logic  replace;
        time_t value;
    } cell_ctl_t;

endpackage
`default_nettype wire

FILE: design/cms_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_cell
// One slot of the sorted free-time row. Takes its neighbors' values and
// moves to its new place on an insert or a replace-earliest request.
// ----------------------------------------------------------------------------
module cms_cell #(
    parameter bit IS_FIRST = 1'b0
) (
    input  wire                logic clk,
    input  wire cms_pkg::cell_ctl_t  ctl,
    input  wire                logic occ_self,
    input  wire                logic occ_next,
    input  wire cms_pkg::time_t      prev_val,
    input  wire cms_pkg::time_t      next_val,
    output cms_pkg::time_t           val
);

    cms_pkg::time_t val_reg;
    cms_pkg::time_t val_next;
    logic           own_lt;
    logic           prev_le;
    logic           r_lt;
    logic           self_le;

    always_comb
    begin
        own_lt  = !occ_self || (ctl.value < val_reg);
        prev_le = IS_FIRST || (ctl.value >= prev_val);
        r_lt    = !occ_next || (ctl.value < next_val);
        self_le = IS_FIRST || (ctl.value >= val_reg);
        val_next = val_reg;
        if (ctl.apply)
        begin
            if (ctl.replace)
            begin
                if (r_lt)
                begin
                    val_next = self_le ? ctl.value : val_reg;
                end
                else
                begin
                    val_next = next_val;
                end
            end
            else
            begin
                if (own_lt)
                begin
                    val_next = prev_le ? ctl.value : prev_val;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule
`default_nettype wire

FILE: design/cluster_makespan_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_makespan_scheduler
// List scheduler over a sorted row of processor free times, one cell per
// processor; reports the largest finish time on the last task of a batch.
// ----------------------------------------------------------------------------
// The makespan strobe follows the last task's request through the CALC and APPLY states and the done register.
// Each task passes through accept, finish-time add and row update; no new request is taken until idle.
// The row of cells is updated in the APPLY state of each request, for any processor count.
// Reset clears the occupancy, the running maximum and sets processor_count
// to 1; cell contents are undefined until written, with no clearing pass.
// The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module cluster_makespan_scheduler #(
    parameter int unsigned MAX_PROCESSORS = cms_pkg::MAX_PROCESSORS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [cms_pkg::FIELD_W-1:0]   arrival_time,
    input  wire logic [cms_pkg::FIELD_W-1:0]   duration,
    input  wire logic                          last_task,
    output logic                               done,
    output logic [cms_pkg::TIME_W-1:0]         makespan,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cms_pkg::CFG_W-1:0]     cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_PROCESSORS + 1);
    localparam int unsigned LIM_W = (CNT_W > cms_pkg::CFG_W) ? CNT_W : cms_pkg::CFG_W;

    cms_pkg::state_t             state_reg;
    cms_pkg::state_t             state_next;
    logic [cms_pkg::CFG_W-1:0]   proc_cnt_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    cms_pkg::time_t              latest_reg;
    cms_pkg::time_t              latest_next;
    logic [cms_pkg::FIELD_W-1:0] arrival_reg;
    logic [cms_pkg::FIELD_W-1:0] dur_reg;
    logic                        last_reg;
    logic                        replace_reg;
    cms_pkg::time_t              finish_reg;
    cms_pkg::time_t              finish_next;
    logic                        done_reg;
    logic                        done_next;
    cms_pkg::time_t              makespan_reg;
    cms_pkg::time_t              makespan_next;

    logic [LIM_W-1:0]            pc_ext;
    logic [LIM_W-1:0]            limit;
    logic                        accept;
    logic                        do_push;
    cms_pkg::time_t              start_time;
    logic [cms_pkg::TIME_W:0]    sum;
    cms_pkg::time_t              run_max;
    cms_pkg::cell_ctl_t          ctl;

    cms_pkg::time_t              cell_val [MAX_PROCESSORS];
    logic [MAX_PROCESSORS-1:0]   occ;

    assign accept    = start && (state_reg == cms_pkg::ST_IDLE);
    assign busy      = (state_reg != cms_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == cms_pkg::ST_IDLE) && !start;
    assign done      = done_reg;
    assign makespan  = makespan_reg;

    always_comb
    begin
        pc_ext = LIM_W'(proc_cnt_reg);
        priority if (pc_ext == '0)
        begin
            limit = LIM_W'(1);
        end
        else if (pc_ext > LIM_W'(MAX_PROCESSORS))
        begin
            limit = LIM_W'(MAX_PROCESSORS);
        end
        else
        begin
            limit = pc_ext;
        end
        do_push = LIM_W'(count_reg) < limit;
    end

    // finish time: on a replace, start at the later of arrival and earliest free; saturate
    always_comb
    begin
        if (replace_reg && (cell_val[0] > cms_pkg::TIME_W'(arrival_reg)))
        begin
            start_time = cell_val[0];
        end
        else
        begin
            start_time = cms_pkg::TIME_W'(arrival_reg);
        end
        sum = (cms_pkg::TIME_W+1)'(start_time) + (cms_pkg::TIME_W+1)'(dur_reg);
        finish_next = sum[cms_pkg::TIME_W] ? '1 : sum[cms_pkg::TIME_W-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        latest_next   = latest_reg;
        done_next     = 1'b0;
        makespan_next = makespan_reg;
        run_max       = (finish_reg > latest_reg) ? finish_reg : latest_reg;
        ctl.apply     = 1'b0;
        ctl.replace   = replace_reg;
        ctl.value     = finish_reg;
        unique case (state_reg)
            cms_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cms_pkg::ST_CALC;
                end
            end
            cms_pkg::ST_CALC:
            begin
                state_next = cms_pkg::ST_APPLY;
            end
            cms_pkg::ST_APPLY:
            begin
                state_next = cms_pkg::ST_IDLE;
                ctl.apply  = 1'b1;
                if (last_reg)
                begin
                    count_next    = '0;
                    latest_next   = '0;
                    done_next     = 1'b1;
                    makespan_next = run_max;
                end
                else
                begin
                    latest_next = run_max;
                    if (!replace_reg)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = cms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cms_pkg::ST_IDLE;
            proc_cnt_reg <= cms_pkg::CFG_W'(1);
            count_reg    <= '0;
            latest_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            latest_reg <= latest_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                proc_cnt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arrival_reg <= arrival_time;
            dur_reg     <= duration;
            last_reg    <= last_task;
            replace_reg <= !do_push;
        end
        if (state_reg == cms_pkg::ST_CALC)
        begin
            finish_reg <= finish_next;
        end
        makespan_reg <= makespan_next;
    end

    genvar i;
    generate
        for (i = 0; i < MAX_PROCESSORS; i++)
        begin : g_cell
            cms_pkg::time_t prev_v;
            cms_pkg::time_t next_v;
            logic           occ_n;

            assign occ[i] = count_reg > CNT_W'(i);

            if (i == 0)
            begin : g_head
                assign prev_v = '0;
            end
            else
            begin : g_body
                assign prev_v = cell_val[i-1];
            end

            if (i == MAX_PROCESSORS - 1)
            begin : g_tail
                assign next_v = '0;
                assign occ_n  = 1'b0;
            end
            else
            begin : g_link
                assign next_v = cell_val[i+1];
                assign occ_n  = occ[i+1];
            end

            cms_cell #(
                .IS_FIRST (i == 0)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .occ_self (occ[i]),
                .occ_next (occ_n),
                .prev_val (prev_v),
                .next_val (next_v),
                .val      (cell_val[i])
            );
        end
    endgenerate

endmodule
`default_nettype wire

FILE: design/cms_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_checker
// Port-level checks of request timing and the makespan strobe.
// ----------------------------------------------------------------------------
module cms_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic last_task,
    input wire logic done
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but not busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("strobe longer than one cycle");

    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_task) |-> ##3 done)
        else $error("missing makespan after last request");

    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_task) |-> ##3 !done)
        else $error("makespan without last request");

endmodule

bind cluster_makespan_scheduler cms_checker u_cms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .last_task (last_task),
    .done      (done)
);
`default_nettype wire

FILE: bench/cluster_makespan_scheduler_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_makespan_scheduler_test
// Drives task batches into the makespan scheduler under several processor
// counts, including zero, the row limit and values above it. Each accepted
// task is run through a behavioral list scheduler kept here. Every makespan
// strobe is checked against the oldest predicted value. A short directed run
// covers saturation, waiting on the earliest free time, and a count lowered
// in mid-batch. Random batches follow, with random gaps between requests.
// ----------------------------------------------------------------------------
module cluster_makespan_scheduler_test;

    localparam int unsigned PROC_MAX    = cms_pkg::MAX_PROCESSORS_DEF;
    localparam int unsigned ITEM_TARGET = 1300;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE      = 8;

    typedef logic [cms_pkg::FIELD_W-1:0] field_t;
    typedef logic [cms_pkg::CFG_W-1:0]   count_t;

    localparam field_t FIELD_TOP = '1;

    typedef enum int unsigned {
        MIX_STEADY,
        MIX_WIDE,
        MIX_TOP,
        MIX_BURST
    } batch_mix_t;

    typedef struct {
        field_t arrival;
        field_t run_len;
        logic   closes;
    } sched_task_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    field_t             arrival_time = '0;
    field_t             duration     = '0;
    logic               last_task    = 1'b0;
    logic               done;
    cms_pkg::time_t     makespan;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    count_t             cfg_data     = '0;

    sched_task_t        pending_tasks[$];
    cms_pkg::time_t     makespan_due[$];
    int unsigned        queued_items = 0;
    int unsigned        failures     = 0;
    int unsigned        stall_cycles = 0;
    int unsigned        gap_left     = 0;
    bit                 no_idle      = 1'b0;

    count_t             proc_limit   = count_t'(1);
    cms_pkg::time_t     free_slot[PROC_MAX];
    int unsigned        used_slots   = 0;
    cms_pkg::time_t     latest       = '0;

    cluster_makespan_scheduler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .arrival_time (arrival_time),
        .duration     (duration),
        .last_task    (last_task),
        .done         (done),
        .makespan     (makespan),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic cms_pkg::time_t sat_sum(input cms_pkg::time_t a, input field_t b);
        logic [cms_pkg::TIME_W:0] sum;
        sum = {1'b0, a} + {2'b0, b};
        return sum[cms_pkg::TIME_W] ? '1 : sum[cms_pkg::TIME_W-1:0];
    endfunction

    function automatic int unsigned clamp_count(input count_t v);
        if (v == 0)
            return 1;
        if (v > PROC_MAX)
            return PROC_MAX;
        return 32'(v);
    endfunction

    task automatic schedule_task(input field_t arr,
                                 input field_t dur,
                                 input logic   closes);
        int unsigned    min_idx;
        cms_pkg::time_t begin_at;
        cms_pkg::time_t finish;
        if (used_slots < clamp_count(proc_limit))
        begin
            finish = sat_sum({1'b0, arr}, dur);
            free_slot[used_slots] = finish;
            used_slots++;
        end
        else
        begin
            min_idx = 0;
            for (int unsigned i = 1; i < used_slots; i++)
                if (free_slot[i] < free_slot[min_idx])
                    min_idx = i;
            begin_at = (free_slot[min_idx] > {1'b0, arr}) ? free_slot[min_idx] : {1'b0, arr};
            finish = sat_sum(begin_at, dur);
            free_slot[min_idx] = finish;
        end
        if (finish > latest)
            latest = finish;
        if (closes)
        begin
            makespan_due.push_back(latest);
            used_slots = 0;
            latest = '0;
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            last_task <= 1'b0;
            gap_left  <= 0;
        end
        else if ((start && !busy) || !start)
        begin
            if ((start || gap_left == 0) && (!start || gap_left == 0)
                && pending_tasks.size() != 0)
            begin
                start        <= 1'b1;
                arrival_time <= pending_tasks[0].arrival;
                duration     <= pending_tasks[0].run_len;
                last_task    <= pending_tasks[0].closes;
                gap_left     <= pick_gap();
                void'(pending_tasks.pop_front());
            end
            else
            begin
                start <= 1'b0;
                if (!start && gap_left != 0)
                    gap_left <= gap_left - 1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cms_pkg::time_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                proc_limit = cfg_data;
            if (start && !busy)
                schedule_task(arrival_time, duration, last_task);
            if (done)
            begin
                if (makespan_due.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("makespan %h with no request pending", makespan);
                end
                else
                begin
                    want = makespan_due.pop_front();
                    if (makespan !== want)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("makespan mismatch: expected %h, got %h", want, makespan);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL cluster_makespan_scheduler");
            $finish;
        end
    end

    task automatic add_task(input field_t arr,
                            input field_t dur,
                            input logic   closes);
        sched_task_t t;
        t.arrival = arr;
        t.run_len = dur;
        t.closes  = closes;
        pending_tasks.push_back(t);
        queued_items++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_tasks.size() != 0 || start || busy || makespan_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(input count_t v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic count_t pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return count_t'($urandom_range(1, 4));
        if (r < 70)
            return count_t'($urandom_range(5, 16));
        if (r < 80)
            return count_t'($urandom_range(17, 64));
        if (r < 86)
            return count_t'(64);
        if (r < 92)
            return count_t'($urandom_range(65, 127));
        if (r < 96)
            return count_t'(0);
        return count_t'(127);
    endfunction

    task automatic queue_batch(input int unsigned n, input batch_mix_t mix, input bit closed);
        field_t arr;
        field_t dur;
        arr = field_t'($urandom_range(0, 1000));
        for (int unsigned i = 0; i < n; i++)
        begin
            case (mix)
                MIX_STEADY:
                begin
                    arr = arr + field_t'($urandom_range(0, 50));
                    dur = field_t'($urandom_range(1, 200));
                end
                MIX_WIDE:
                begin
                    arr = field_t'($urandom());
                    dur = field_t'($urandom());
                end
                MIX_TOP:
                begin
                    arr = FIELD_TOP - field_t'($urandom_range(0, 255));
                    dur = ($urandom_range(0, 1) == 0)
                        ? FIELD_TOP - field_t'($urandom_range(0, 255))
                        : field_t'($urandom_range(0, 1000));
                end
                default:
                begin
                    arr = '0;
                    dur = field_t'($urandom_range(0, 500));
                end
            endcase
            add_task(arr, dur, closed && (i == n - 1));
        end
    endtask

    initial
    begin
        int unsigned     lim;
        int unsigned     phase_items;
        int unsigned     target;
        int unsigned     n;
        int unsigned     r;
        batch_mix_t      mix;
        count_t          cnt;
        bit              closed;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset count of one: empty task, saturation, wait on free time
        add_task('0, '0, 1'b1);
        add_task(FIELD_TOP, FIELD_TOP, 1'b0);
        add_task('0, field_t'(5), 1'b1);
        add_task(field_t'(100), field_t'(10), 1'b0);
        add_task(field_t'(50), field_t'(5), 1'b0);
        add_task(field_t'(200), field_t'(3), 1'b1);
        add_task(FIELD_TOP, '0, 1'b1);
        add_task('0, FIELD_TOP, 1'b1);
        wait_idle();
        write_count(count_t'(0));
        add_task(field_t'(5), field_t'(5), 1'b0);
        add_task(field_t'(1), field_t'(1), 1'b1);
        wait_idle();
        write_count(count_t'(127));
        add_task(field_t'(7), field_t'(1), 1'b0);
        add_task(field_t'(3), field_t'(2), 1'b1);
        wait_idle();
        write_count(count_t'(3));
        add_task('0, field_t'(10), 1'b0);
        add_task('0, field_t'(20), 1'b0);
        add_task('0, field_t'(30), 1'b0);
        wait_idle();
        write_count(count_t'(2));
        add_task('0, field_t'(1), 1'b0);
        add_task('0, field_t'(1), 1'b1);

        while (queued_items < ITEM_TARGET)
        begin
            wait_idle();
            cnt = pick_count();
            write_count(cnt);
            lim = clamp_count(cnt);
            no_idle = ($urandom_range(0, 4) == 0);
            target = $urandom_range(30, 120);
            phase_items = 0;
            while (phase_items < target)
            begin
                n = $urandom_range(1, 2 * lim + 3);
                r = $urandom_range(0, 99);
                mix = (r < 45) ? MIX_STEADY : (r < 65) ? MIX_BURST : (r < 85) ? MIX_WIDE : MIX_TOP;
                closed = !(phase_items + n >= target && $urandom_range(0, 3) == 0);
                queue_batch(n, mix, closed);
                phase_items += n;
            end
        end

        wait_idle();
        if (makespan_due.size() != 0)
            failures++;
        if (failures == 0)
            $display("PASS cluster_makespan_scheduler");
        else
            $display("FAIL cluster_makespan_scheduler");
        $finish;
    end

endmodule
`default_nettype wire
